[sv/swm_pkg.sv]
// Shared types and constants for the sliding window maximum block.
`default_nettype none

package swm_pkg;

  localparam int VALUE_W = 32;
  localparam int WIN_REG_W = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last_sample;
  } swm_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] window_max;
    logic                      last_result;
  } swm_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRONT,
    S_BACK,
    S_APPEND,
    S_OUT
  } swm_state_t;

  // Which deque slot the single read port looks at.
  typedef enum logic [1:0] {
    RD_FRONT,
    RD_FRONT_NEXT,
    RD_BACK,
    RD_BACK_PREV
  } swm_rsel_t;

  typedef struct packed {
    logic      accept;
    logic      rd_en;
    swm_rsel_t rd_sel;
    logic      drop_front;
    logic      evict_back;
    logic      append;
    logic      load_out;
    logic      finish;
  } swm_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic front_aged;
    logic back_not_greater;
    logic result_due;
    logic out_free;
  } swm_stat_t;

endpackage

`default_nettype wire

[sv/sliding_window_maximum.sv]
// Top level of the streaming sliding window maximum filter.
// Signed 32-bit samples come in on the sample request channel and, once
// window_size samples of the current sequence have arrived, every sample
// returns the maximum of the last window_size samples on the result channel;
// a sample flagged last_sample ends the sequence, marks its result (if any)
// with last_result, and clears all sequence state, so a sequence shorter than
// the window yields no result at all. Candidates live in a monotonic deque
// held in a single-port-read ring memory of MAX_WINDOW entries, and one
// sequencer walks it a slot per cycle: a request takes an accept step, an
// append step and a result step, plus one deque read per entry aged off the
// front, one to look at a front that stays, one per entry evicted from the
// back and one to look at a back that stays. Each sample enters and leaves
// the deque at most once. The result sits in an output register, so the next
// request is taken while a result waits; a request only stalls at its end if
// the previous result has still not been taken. window_size is 0 -> 1 and
// saturates at MAX_WINDOW; write it only while the block is idle.
`default_nettype none

module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  input  wire swm_in_t              sample_req,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output swm_out_t                  result_req,
  input  wire logic                 window_we,
  input  wire logic [WIN_REG_W-1:0] window_data
);

  swm_cmd_t  cmd;
  swm_stat_t stat;

  // sequencer: accept, trim front, evict back, append, hand over the result
  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // deque memory, pointers, counters and the result register
  swm_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample_req   (sample_req),
    .window_we    (window_we),
    .window_data  (window_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_req   (result_req),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire

[sv/swm_ctrl.sv]
// Sequencer that walks the deque front and back for one request at a time.
`default_nettype none

module swm_ctrl
  import swm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      sample_valid,
  output logic           sample_stall,
  input  wire swm_stat_t stat,
  output swm_cmd_t       cmd
);

  swm_state_t state;
  swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.rd_sel   = RD_FRONT;
    sample_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.accept = 1'b1;
          if (stat.count_zero) begin
            state_next = S_APPEND;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_FRONT;
            state_next = S_FRONT;
          end
        end
      end
      S_FRONT: begin
        if (stat.front_aged) begin
          cmd.drop_front = 1'b1;
          if (stat.count_one) begin
            state_next = S_APPEND;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_FRONT_NEXT;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BACK;
          state_next = S_BACK;
        end
      end
      S_BACK: begin
        if (stat.back_not_greater) begin
          cmd.evict_back = 1'b1;
          if (stat.count_one) begin
            state_next = S_APPEND;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_BACK_PREV;
          end
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        // fetch the front for the result unless the new sample becomes the front
        if (!stat.count_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FRONT;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.result_due) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/swm_dp.sv]
// Datapath: deque ring memory, pointers, sample counters and result register.
`default_nettype none

module swm_dp
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swm_in_t              sample_req,
  input  wire logic                 window_we,
  input  wire logic [WIN_REG_W-1:0] window_data,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output swm_out_t                  result_req,
  input  wire swm_cmd_t             cmd,
  output swm_stat_t                 stat
);

  localparam int IDX_W   = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int POS_MOD = 2 * MAX_WINDOW;
  localparam int POS_W   = $clog2(POS_MOD);

  logic signed [VALUE_W-1:0] val_mem [MAX_WINDOW];
  logic [POS_W-1:0]          pos_mem [MAX_WINDOW];

  logic [WIN_REG_W-1:0]      window_size;
  logic [IDX_W-1:0]          front;
  logic [CNT_W-1:0]          count;
  logic [POS_W-1:0]          position;
  logic [CNT_W-1:0]          seen;
  logic signed [VALUE_W-1:0] sample_r;
  logic                      last_r;
  logic                      front_is_sample;
  logic signed [VALUE_W-1:0] rd_val;
  logic [POS_W-1:0]          rd_pos;

  logic [CNT_W-1:0]          win_eff;
  logic [IDX_W-1:0]          rd_off;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          wr_addr;
  logic [IDX_W-1:0]          front_inc;
  logic [POS_W-1:0]          position_inc;
  logic [POS_W:0]            age_ext;
  logic [POS_W-1:0]          age;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    begin
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(MAX_WINDOW)) begin
        sum = sum - (IDX_W+1)'(MAX_WINDOW);
      end
      ring_add = sum[IDX_W-1:0];
    end
  endfunction

  // zero acts as one, anything above the deque depth saturates
  always_comb begin
    if (window_size == '0) begin
      win_eff = CNT_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_size);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_FRONT:      rd_off = '0;
      RD_FRONT_NEXT: rd_off = IDX_W'(1);
      RD_BACK:       rd_off = IDX_W'(count - CNT_W'(1));
      RD_BACK_PREV:  rd_off = IDX_W'(count - CNT_W'(2));
      default:       rd_off = '0;
    endcase
  end

  assign rd_addr      = ring_add(front, rd_off);
  assign wr_addr      = ring_add(front, IDX_W'(count));
  assign front_inc    = (front == IDX_W'(MAX_WINDOW - 1)) ? '0 : front + IDX_W'(1);
  assign position_inc = (position == POS_W'(POS_MOD - 1)) ? '0 : position + POS_W'(1);

  // age of the entry just read, modulo the position range
  assign age_ext = {1'b0, position} - {1'b0, rd_pos}
                 + ((position < rd_pos) ? (POS_W+1)'(POS_MOD) : '0);
  assign age     = age_ext[POS_W-1:0];

  assign stat.count_zero       = (count == '0);
  assign stat.count_one        = (count == CNT_W'(1));
  assign stat.front_aged       = (age >= POS_W'(win_eff));
  assign stat.back_not_greater = (rd_val <= sample_r);
  assign stat.result_due       = (seen >= win_eff);
  assign stat.out_free         = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (cmd.append && (count < CNT_W'(MAX_WINDOW))) begin
      val_mem[wr_addr] <= sample_r;
      pos_mem[wr_addr] <= position;
    end
    if (cmd.rd_en) begin
      rd_val <= val_mem[rd_addr];
      rd_pos <= pos_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= sample_req.sample_value;
      last_r   <= sample_req.last_sample;
    end
    if (cmd.append) begin
      front_is_sample <= (count == '0);
    end
    if (cmd.load_out) begin
      result_req.window_max  <= front_is_sample ? sample_r : rd_val;
      result_req.last_result <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WIN_REG_W'(1);
      front        <= '0;
      count        <= '0;
      position     <= '0;
      seen         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (window_we) begin
        window_size <= window_data;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end
      if (cmd.drop_front) begin
        front <= front_inc;
        count <= count - CNT_W'(1);
      end
      if (cmd.evict_back) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.append) begin
        if (count < CNT_W'(MAX_WINDOW)) begin
          count <= count + CNT_W'(1);
        end
        position <= position_inc;
        if (seen < CNT_W'(MAX_WINDOW)) begin
          seen <= seen + CNT_W'(1);
        end
      end
      if (cmd.finish && last_r) begin
        front    <= '0;
        count    <= '0;
        position <= '0;
        seen     <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WINDOW))
    else $error("deque count beyond depth");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= CNT_W'(MAX_WINDOW))
    else $error("sample count beyond saturation");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && last_r |=> count == '0 && seen == '0 && position == '0)
    else $error("sequence state not cleared after final sample");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !result_valid || !result_stall)
    else $error("result register overwritten while held");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_front || cmd.evict_back |-> count != '0)
    else $error("pop from empty deque");
`endif

endmodule

`default_nettype wire

[tb/sliding_window_maximum_tb.sv]
// Self-checking testbench for the sliding window maximum filter.
`default_nettype none

module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam int MAXW = 64;
  localparam int SETTLE_CYCLES = 300;   // longest request walk is well under this
  localparam int STALL_LIMIT = 5000;    // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct {
    swm_in_t req;
    bit      drain;   // hold this request back until all results are in
  } staged_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  swm_in_t              sample_req = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  swm_out_t             result_req;
  logic                 window_we = 1'b0;
  logic [WIN_REG_W-1:0] window_data = '0;

  sliding_window_maximum #(.MAX_WINDOW(MAXW)) DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_req   (sample_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_req   (result_req),
    .window_we    (window_we),
    .window_data  (window_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  staged_t  sample_queue [$];
  swm_out_t results_due [$];
  bit       sample_taken = 1'b0;
  bit       calm = 1'b0;
  bit       hold_go = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  int       errors = 0;
  int       n_samples = 0;
  int       n_results = 0;
  int       n_writes = 0;
  int       idle_cycles = 0;

  // Mirror of the filter state: candidate ring, sequence counters, window register.
  logic signed [VALUE_W-1:0] dq_val [MAXW];
  int                        dq_pos [MAXW];
  int                        dq_head, dq_len, next_pos, seq_len;
  logic [WIN_REG_W-1:0]      win_copy;

  task automatic clear_mirror();
    for (int i = 0; i < MAXW; i++) begin
      dq_val[i] = '0;
      dq_pos[i] = 0;
    end
    dq_head = 0;
    dq_len = 0;
    next_pos = 0;
    seq_len = 0;
    win_copy = 1;
  endtask

  // Advance the mirror by one sample and return the running maximum, if due.
  task automatic slide_window_max(input swm_in_t s, output bit has, output swm_out_t r);
    int w, pos, bi, age;
    w = (win_copy == 0) ? 1 : (int'(win_copy) > MAXW) ? MAXW : int'(win_copy);
    pos = next_pos;
    // drop aged candidates from the front
    while (dq_len > 0) begin
      age = (pos + 2 * MAXW - dq_pos[dq_head]) % (2 * MAXW);
      if (age < w) break;
      dq_head = (dq_head + 1) % MAXW;
      dq_len--;
    end
    // evict candidates that are not greater than the new sample
    while (dq_len > 0) begin
      bi = (dq_head + dq_len - 1) % MAXW;
      if (dq_val[bi] > s.sample_value) break;
      dq_len--;
    end
    if (dq_len < MAXW) begin
      bi = (dq_head + dq_len) % MAXW;
      dq_val[bi] = s.sample_value;
      dq_pos[bi] = pos;
      dq_len++;
    end
    if (seq_len < MAXW) seq_len++;
    has = (seq_len >= w);
    r.window_max = dq_val[dq_head];
    r.last_result = s.last_sample;
    next_pos = (pos + 1) % (2 * MAXW);
    if (s.last_sample) begin
      dq_head = 0;
      dq_len = 0;
      next_pos = 0;
      seq_len = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Sample side: present a new request only once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      if (sample_queue.size() != 0 && !(sample_queue[0].drain && results_due.size() != 0)
          && (calm || $urandom_range(0, 99) >= 8)) begin
        sample_req <= sample_queue[0].req;
        sample_valid <= 1'b1;
        void'(sample_queue.pop_front());
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  // Predict on every taken sample, check every taken result.
  always @(posedge clk) begin
    swm_out_t want;
    bit       has;
    if (rst) begin
      clear_mirror();
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && !sample_stall;
      if (window_we) begin
        win_copy = window_data;
        n_writes++;
      end
      if (sample_valid && !sample_stall) begin
        slide_window_max(sample_req, has, want);
        n_samples++;
        if (has) results_due.push_back(want);
      end
      if (result_valid && !result_stall) begin
        n_results++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result max=%0d last=%0b",
                                    $signed(result_req.window_max), result_req.last_result));
        end else begin
          want = results_due.pop_front();
          if (result_req.window_max !== want.window_max)
            report_mismatch($sformatf("window_max got %0d expected %0d",
                                      $signed(result_req.window_max),
                                      $signed(want.window_max)));
          if (result_req.last_result !== want.last_result)
            report_mismatch($sformatf("last_result got %0b expected %0b",
                                      result_req.last_result, want.last_result));
        end
      end
    end
  end

  // Watchdog: give up when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) || window_we)
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic stage(input logic signed [VALUE_W-1:0] v, input bit last);
    staged_t st;
    st.req.sample_value = v;
    st.req.last_sample = last;
    st.drain = 1'b0;
    sample_queue.push_back(st);
  endtask

  // Wait until every request is taken and every result is in, then let the
  // block finish any request that yields no result.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || sample_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input int v);
    wait_idle();
    @(negedge clk);
    window_we <= 1'b1;
    window_data <= v[WIN_REG_W-1:0];
    @(negedge clk);
    window_we <= 1'b0;
    @(posedge clk);
  endtask

  // Queue one sequence with a random value pattern; an open sequence runs on
  // into whatever is queued after it.
  task automatic queue_sequence(input int len, input bit close);
    int                        mode;
    logic signed [VALUE_W-1:0] v;
    staged_t                   st;
    mode = $urandom_range(0, 5);
    v = $urandom();
    for (int i = 0; i < len; i++) begin
      case (mode)
        2: v = int'($urandom_range(0, 8)) - 4;      // many equal values
        3: v = v - int'($urandom_range(0, 3000));   // falling run fills the ring
        4: v = v + int'($urandom_range(0, 3000));   // rising run evicts
        5: begin
          case ($urandom_range(0, 3))
            0: v = VMIN;
            1: v = VMAX;
            2: v = '0;
            default: v = $urandom();
          endcase
        end
        default: v = $urandom();
      endcase
      st.req.sample_value = v;
      st.req.last_sample = close && (i == len - 1);
      st.drain = ($urandom_range(0, 49) == 0);
      sample_queue.push_back(st);
    end
  endtask

  initial begin
    int phase_windows [11];
    int w, len, queued, pick;
    staged_t st;
    swm_out_t miss;

    phase_windows = '{2, 64, 5, 127, 1, 17, 0, 65, 8, 33, 3};
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset window of one, value extremes.
    stage(VMIN, 1'b0);
    stage(VMAX, 1'b0);
    stage('0, 1'b0);
    stage(-1, 1'b1);
    // Zero window acts as one.
    write_window(0);
    stage(-1, 1'b0);
    stage(32'h5555_5555, 1'b1);
    // Window of three: equal neighbors, extremes, then a too-short sequence.
    write_window(3);
    stage(9, 1'b0);
    stage(9, 1'b0);
    stage(4, 1'b0);
    stage(VMIN, 1'b0);
    stage(VMAX, 1'b0);
    stage(2, 1'b0);
    stage(2, 1'b1);
    stage(8, 1'b0);
    stage(-8, 1'b1);
    // Shrink the window in mid-sequence.
    write_window(4);
    stage(10, 1'b0);
    stage(20, 1'b0);
    stage(30, 1'b0);
    write_window(2);
    stage(5, 1'b0);
    stage(1, 1'b1);

    // Random phases over a spread of window settings, saturation included.
    for (int p = 0; p < 11; p++) begin
      write_window(phase_windows[p]);
      calm = (p == 6);
      w = (phase_windows[p] == 0) ? 1 : (phase_windows[p] > MAXW) ? MAXW : phase_windows[p];
      queued = 0;
      if (p == 5) begin
        // pause the sender until the previous phase is fully drained
        st.req.sample_value = VMAX;
        st.req.last_sample = 1'b1;
        st.drain = 1'b1;
        sample_queue.push_back(st);
        queued++;
      end
      while (queued < 50) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) len = $urandom_range(1, (w > 1) ? w - 1 : 1);
        else if (pick < 8) len = w + $urandom_range(0, (w > 32) ? 10 : 20);
        else len = $urandom_range(1, 5);
        queue_sequence(len, $urandom_range(0, 5) != 0);
        queued += len;
      end
      if (p == 2) hold_go = 1'b1;
    end

    wait_idle();
    calm = 1'b0;
    while (results_due.size() != 0) begin
      miss = results_due.pop_front();
      report_mismatch($sformatf("missing result max=%0d", $signed(miss.window_max)));
    end
    $display("Covered %0d samples and %0d results over %0d window writes,",
             n_samples, n_results, n_writes);
    $display("window sizes 0 to 127 with stalls, a long result hold-off and a drain pause.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/swm_pkg.sv
sv/swm_ctrl.sv
sv/swm_dp.sv
sv/sliding_window_maximum.sv
tb/sliding_window_maximum_tb.sv
